// ===== hdl/ctsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsc_pkg: shared types and constants of the clock time-set controller
// Event codes, edit modes, item structs and the binary to two-digit split.
// ----------------------------------------------------------------------------
package ctsc_pkg;

  localparam int unsigned DIGIT_BASE  = 10;
  localparam int unsigned HOUR_MOD    = 24;
  localparam int unsigned MINUTE_MOD  = 60;

  // Event codes carried in the kind field. Codes 6 and 7 are unused.
  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_UP    = 3'd1,
    KIND_DOWN  = 3'd2,
    KIND_SHORT = 3'd3,
    KIND_LONG  = 3'd4,
    KIND_BLINK = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_HOUR   = 2'd1,
    MODE_MINUTE = 2'd2,
    MODE_SECOND = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] rtc_hours;
    logic [5:0] rtc_minutes;
    logic [5:0] rtc_seconds;
  } event_item_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
  } digits_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    mode_t      mode;
    logic       blink_on;
    logic       commit_pulse;
    logic       leave_screen;
  } result_item_t;

  typedef struct packed {
    mode_t   mode;
    digits_t digits;
    logic    skip_release;
    logic    blink_phase;
  } ctsc_state_t;

  // Splits a value below 64 into a tens digit (upper three bits) and a
  // units digit (lower four bits).
  function automatic logic [6:0] split_bcd(input logic [5:0] value);
    logic [2:0] tens;
    logic [5:0] rest;
    if (value >= 6'd60) begin
      tens = 3'd6;
    end else if (value >= 6'd50) begin
      tens = 3'd5;
    end else if (value >= 6'd40) begin
      tens = 3'd4;
    end else if (value >= 6'd30) begin
      tens = 3'd3;
    end else if (value >= 6'd20) begin
      tens = 3'd2;
    end else if (value >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    rest = value - 6'({3'b000, tens} * 6'(DIGIT_BASE));
    return {tens, rest[3:0]};
  endfunction

endpackage

// ===== hdl/ctsc_field_step.sv =====
// ----------------------------------------------------------------------------
// ctsc_field_step: one step up or down of a two-digit time field
// Wraps modulo 24 for hours and modulo 60 for minutes and seconds.
// ----------------------------------------------------------------------------
module ctsc_field_step
  import ctsc_pkg::*;
(
  input  logic [2:0] tens,
  input  logic [3:0] units,
  input  logic       is_hour,
  input  logic       up,
  output logic [2:0] tens_next,
  output logic [3:0] units_next
);

  logic [6:0] value;
  logic [7:0] modulus;
  logic [7:0] sum;
  logic [7:0] reduced;
  logic [6:0] split;

  assign value   = 7'({4'b0000, tens} * 7'(DIGIT_BASE)) + {3'b000, units};
  assign modulus = is_hour ? 8'(HOUR_MOD) : 8'(MINUTE_MOD);

  // An out-of-range field loaded from the RTC can sit above the modulus,
  // so a down step may need two subtractions to come back into range.
  always_comb begin
    if (up) begin
      sum = {1'b0, value} + 8'd1;
    end else begin
      sum = {1'b0, value} + modulus - 8'd1;
    end
    if (sum >= {modulus[6:0], 1'b0}) begin
      reduced = sum - {modulus[6:0], 1'b0};
    end else if (sum >= modulus) begin
      reduced = sum - modulus;
    end else begin
      reduced = sum;
    end
  end

  assign split      = split_bcd(reduced[5:0]);
  assign tens_next  = split[6:4];
  assign units_next = split[3:0];

endmodule

// ===== hdl/ctsc_update.sv =====
// ----------------------------------------------------------------------------
// ctsc_update: next state and result for one event
// Decodes the event against the current mode and builds the new state.
// ----------------------------------------------------------------------------
module ctsc_update
  import ctsc_pkg::*;
(
  input  event_item_t  item,
  input  ctsc_state_t  state,
  output ctsc_state_t  state_next,
  output result_item_t result
);

  mode_t      mode_next;
  logic [2:0] sel_tens;
  logic [3:0] sel_units;
  logic [2:0] step_tens;
  logic [3:0] step_units;
  logic [6:0] rtc_hour_split;
  logic [6:0] rtc_minute_split;
  logic [6:0] rtc_second_split;
  logic       commit;
  logic       leave;

  // Pick the field under edit for the shared step unit.
  always_comb begin
    unique case (state.mode)
      MODE_HOUR: begin
        sel_tens  = {1'b0, state.digits.hour_tens};
        sel_units = state.digits.hour_units;
      end
      MODE_MINUTE: begin
        sel_tens  = state.digits.minute_tens;
        sel_units = state.digits.minute_units;
      end
      default: begin
        sel_tens  = state.digits.second_tens;
        sel_units = state.digits.second_units;
      end
    endcase
  end

  ctsc_field_step u_step (
    .tens       (sel_tens),
    .units      (sel_units),
    .is_hour    (state.mode == MODE_HOUR),
    .up         (item.kind == KIND_UP),
    .tens_next  (step_tens),
    .units_next (step_units)
  );

  assign rtc_hour_split   = split_bcd({1'b0, item.rtc_hours});
  assign rtc_minute_split = split_bcd(item.rtc_minutes);
  assign rtc_second_split = split_bcd(item.rtc_seconds);

  // Mode transitions.
  always_comb begin
    mode_next = state.mode;
    unique case (item.kind)
      KIND_SHORT: begin
        if (!state.skip_release && state.mode != MODE_NORMAL) begin
          mode_next = (state.mode == MODE_SECOND) ? MODE_NORMAL : mode_t'(state.mode + 2'd1);
        end
      end
      KIND_LONG: begin
        mode_next = (state.mode == MODE_NORMAL) ? MODE_HOUR : MODE_NORMAL;
      end
      default: begin
        mode_next = state.mode;
      end
    endcase
  end

  // Digits, flags and pulses.
  always_comb begin
    state_next      = state;
    state_next.mode = mode_next;
    commit          = 1'b0;
    leave           = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        if (state.mode == MODE_NORMAL) begin
          state_next.digits.hour_tens    = rtc_hour_split[5:4];
          state_next.digits.hour_units   = rtc_hour_split[3:0];
          state_next.digits.minute_tens  = rtc_minute_split[6:4];
          state_next.digits.minute_units = rtc_minute_split[3:0];
          state_next.digits.second_tens  = rtc_second_split[6:4];
          state_next.digits.second_units = rtc_second_split[3:0];
        end
      end
      KIND_UP, KIND_DOWN: begin
        case (state.mode)
          MODE_HOUR: begin
            state_next.digits.hour_tens  = step_tens[1:0];
            state_next.digits.hour_units = step_units;
          end
          MODE_MINUTE: begin
            state_next.digits.minute_tens  = step_tens;
            state_next.digits.minute_units = step_units;
          end
          MODE_SECOND: begin
            state_next.digits.second_tens  = step_tens;
            state_next.digits.second_units = step_units;
          end
          default: begin
          end
        endcase
      end
      KIND_SHORT: begin
        if (!state.skip_release) begin
          if (state.mode == MODE_NORMAL) begin
            leave = 1'b1;
          end else if (state.mode == MODE_SECOND) begin
            commit                 = 1'b1;
            state_next.blink_phase = 1'b0;
          end
        end
        state_next.skip_release = 1'b0;
      end
      KIND_LONG: begin
        state_next.skip_release = 1'b1;
      end
      KIND_BLINK: begin
        if (state.mode != MODE_NORMAL) begin
          state_next.blink_phase = ~state.blink_phase;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.hour_tens    = state_next.digits.hour_tens;
  assign result.hour_units   = state_next.digits.hour_units;
  assign result.minute_tens  = state_next.digits.minute_tens;
  assign result.minute_units = state_next.digits.minute_units;
  assign result.second_tens  = state_next.digits.second_tens;
  assign result.second_units = state_next.digits.second_units;
  assign result.mode         = state_next.mode;
  assign result.blink_on     = state_next.blink_phase;
  assign result.commit_pulse = commit;
  assign result.leave_screen = leave;

endmodule

// ===== hdl/clock_time_set_controller_core.sv =====
// ----------------------------------------------------------------------------
// clock_time_set_controller_core: button-driven time-setting controller
// Holds the edit mode, six display digits, blink phase and skip-release
// flag, and returns one result item for every event item.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                   Payload
//   event     in          event_valid / event_ready   event_item  (event_item_t)
//   result    out         result_valid / result_ready result_item (result_item_t)
//
// Every event item gives exactly one result item. An accepted event item
// waits in the input register; the update logic then writes both the
// state and the result register at the same edge. While the result side
// does not stall, a new item can be accepted every cycle.
// Reset returns to normal mode with all digits, blink and skip-release clear.
// A stalled result holds the input register; event_ready stays high while
// that register is empty or is moving on in the same cycle.
//
module clock_time_set_controller_core
  import ctsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         event_valid,
  output logic         event_ready,
  input  event_item_t  event_item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  // Input register: one event waiting for the update logic.
  event_item_t  hold;
  logic         full;
  logic         advance;

  // Controller state, written only when an item moves to the result register.
  ctsc_state_t  state;
  ctsc_state_t  state_next;
  result_item_t result_next;

  // The held item moves on when the result register is empty or is being
  // emptied in this same cycle.
  assign advance     = full && (!result_valid || result_ready);
  assign event_ready = !full || advance;

  ctsc_update u_update (
    .item       (hold),
    .state      (state),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      full                      <= 1'b0;
      result_valid              <= 1'b0;
      state.mode                <= MODE_NORMAL;
      state.digits              <= '0;
      state.skip_release        <= 1'b0;
      state.blink_phase         <= 1'b0;
    end else begin
      if (event_valid && event_ready) begin
        full <= 1'b1;
      end else if (advance) begin
        full <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        state        <= state_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (event_valid && event_ready) begin
      hold <= event_item;
    end
    if (advance) begin
      result_item <= result_next;
    end
  end

endmodule

// ===== hdl/ctsc_checker.sv =====
// ----------------------------------------------------------------------------
// ctsc_checker: port-level checks of the clock time-set controller
// Watches the result channel for stalls and for pulses that cannot coexist.
// ----------------------------------------------------------------------------
module ctsc_checker
  import ctsc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         event_valid,
  input logic         event_ready,
  input event_item_t  event_item,
  input logic         result_valid,
  input logic         result_ready,
  input result_item_t result_item
);

  // An event item that is offered but not taken stays offered unchanged.
  assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=> event_valid && $stable(event_item))
    else $error("event item changed while waiting");

  // A result held back by the consumer keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("result item changed while stalled");

  // A commit ends editing: back in normal mode with the blink phase cleared.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.commit_pulse |->
      result_item.mode == MODE_NORMAL && !result_item.blink_on)
    else $error("commit outside normal mode or with blink set");

  // Leaving the screen happens only from normal mode and never with a commit.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.leave_screen |->
      result_item.mode == MODE_NORMAL && !result_item.commit_pulse)
    else $error("leave screen with wrong mode or with commit");

  // Units digits always come out of a split and stay decimal.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.hour_units <= 4'd9 && result_item.minute_units <= 4'd9
      && result_item.second_units <= 4'd9)
    else $error("units digit above nine");

endmodule

bind clock_time_set_controller_core ctsc_checker u_ctsc_checker (.*);

// ===== tb/sv/ctsc_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctsc_result_checker: prediction and comparison for the time-set controller
// Watches the event and result channels. It predicts one result item per
// accepted event item and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module ctsc_result_checker
  import ctsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         event_valid,
  input  logic         event_ready,
  input  event_item_t  event_item,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_item_t result_item,
  output int unsigned  mismatches,
  output int unsigned  pending
);

  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow copy of the controller state.
  mode_t        cur_mode;
  int unsigned  digit [6];
  logic         skip_next_short;
  logic         blink_phase;

  result_item_t predicted_results [$];
  int unsigned  fail_count = 0;
  int unsigned  waiting = 0;

  assign mismatches = fail_count;
  assign pending    = waiting;

  function automatic void load_pair(input int unsigned pos, input int unsigned value);
    digit[pos]     = (value / DIGIT_BASE) & 4'hF;
    digit[pos + 1] = value % DIGIT_BASE;
  endfunction

  // Up or down on the field selected by the edit mode, with wrap-around.
  function automatic void step_field(input logic up);
    int unsigned pos;
    int unsigned modulus;
    int unsigned value;
    case (cur_mode)
      MODE_HOUR: begin
        pos = 0;
        modulus = HOUR_MOD;
      end
      MODE_MINUTE: begin
        pos = 2;
        modulus = MINUTE_MOD;
      end
      MODE_SECOND: begin
        pos = 4;
        modulus = MINUTE_MOD;
      end
      default: return;
    endcase
    value = digit[pos] * DIGIT_BASE + digit[pos + 1];
    value = up ? (value + 1) % modulus : (value + modulus - 1) % modulus;
    load_pair(pos, value);
  endfunction

  function automatic result_item_t predict_display(input event_item_t ev);
    result_item_t r;
    logic         commit;
    logic         leave;
    commit = 1'b0;
    leave  = 1'b0;
    case (ev.kind)
      KIND_TICK: begin
        if (cur_mode == MODE_NORMAL) begin
          load_pair(0, ev.rtc_hours);
          load_pair(2, ev.rtc_minutes);
          load_pair(4, ev.rtc_seconds);
        end
      end
      KIND_UP:   step_field(1'b1);
      KIND_DOWN: step_field(1'b0);
      KIND_SHORT: begin
        if (!skip_next_short) begin
          if (cur_mode == MODE_NORMAL) begin
            leave = 1'b1;
          end else if (cur_mode == MODE_SECOND) begin
            commit      = 1'b1;
            blink_phase = 1'b0;
            cur_mode    = MODE_NORMAL;
          end else begin
            cur_mode = (cur_mode == MODE_HOUR) ? MODE_MINUTE : MODE_SECOND;
          end
        end
        skip_next_short = 1'b0;
      end
      KIND_LONG: begin
        skip_next_short = 1'b1;
        cur_mode = (cur_mode == MODE_NORMAL) ? MODE_HOUR : MODE_NORMAL;
      end
      KIND_BLINK: begin
        if (cur_mode != MODE_NORMAL) begin
          blink_phase = !blink_phase;
        end
      end
      default: ;
    endcase
    r.hour_tens    = 2'(digit[0]);
    r.hour_units   = 4'(digit[1]);
    r.minute_tens  = 3'(digit[2]);
    r.minute_units = 4'(digit[3]);
    r.second_tens  = 3'(digit[4]);
    r.second_units = 4'(digit[5]);
    r.mode         = cur_mode;
    r.blink_on     = blink_phase;
    r.commit_pulse = commit;
    r.leave_screen = leave;
    return r;
  endfunction

  function automatic int unsigned field_errors(input result_item_t want,
                                               input result_item_t got);
    int unsigned n;
    n = 0;
    if (got.hour_tens !== want.hour_tens) n++;
    if (got.hour_units !== want.hour_units) n++;
    if (got.minute_tens !== want.minute_tens) n++;
    if (got.minute_units !== want.minute_units) n++;
    if (got.second_tens !== want.second_tens) n++;
    if (got.second_units !== want.second_units) n++;
    if (got.mode !== want.mode) n++;
    if (got.blink_on !== want.blink_on) n++;
    if (got.commit_pulse !== want.commit_pulse) n++;
    if (got.leave_screen !== want.leave_screen) n++;
    return n;
  endfunction

  function automatic string show(input result_item_t r);
    return $sformatf("%0d%0d:%0d%0d:%0d%0d mode=%0d blink=%b commit=%b leave=%b",
                     r.hour_tens, r.hour_units, r.minute_tens, r.minute_units,
                     r.second_tens, r.second_units, r.mode, r.blink_on,
                     r.commit_pulse, r.leave_screen);
  endfunction

  always @(posedge clk) begin : monitor
    result_item_t want;
    int unsigned  bad;
    if (rst) begin
      cur_mode        = MODE_NORMAL;
      skip_next_short = 1'b0;
      blink_phase     = 1'b0;
      foreach (digit[i]) digit[i] = 0;
      predicted_results.delete();
    end else begin
      // The result side is handled first, so a result can never be matched
      // against a prediction made from an item accepted at the same edge.
      if (result_valid && result_ready) begin
        if (predicted_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: result item with no prediction waiting: %s",
                     $time, show(result_item));
          end
        end else begin
          want = predicted_results.pop_front();
          bad  = field_errors(want, result_item);
          if (bad != 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: %0d field(s) wrong: expected %s, got %s",
                       $time, bad, show(want), show(result_item));
            end
          end
        end
      end
      if (event_valid && event_ready) begin
        predicted_results.push_back(predict_display(event_item));
      end
    end
    waiting <= predicted_results.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression for the clock time-set controller core
// Drives directed and random button, tick and blink events with random
// gaps and back-pressure; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import ctsc_pkg::*;

  // Kind codes that the controller does not use; they must be ignored.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS    = 1700;
  localparam int unsigned HOLD_OFF_CYCLES = 40;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic         clk;
  logic         rst;
  logic         event_valid;
  logic         event_ready;
  event_item_t  event_item;
  logic         result_valid;
  logic         result_ready;
  result_item_t result_item;

  int unsigned  mismatches;
  int unsigned  pending;
  int unsigned  items_sent = 0;

  // Shared between the two driving processes: idle_on enables random gaps
  // on both sides, and hold_off_req asks the result side for one long stall.
  logic         idle_on = 1'b1;
  logic         hold_off_req = 1'b0;

  clock_time_set_controller_core dut (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_item   (event_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  ctsc_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_item   (event_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: far beyond the slowest legal run, where every item sees the
  // longest sender gap and the longest receiver stall.
  initial begin
    #10_000_000;
    $display("clock_time_set_controller_core regression: fail");
    $finish;
  end

  // Gap length in cycles: mostly short, sometimes medium, rarely long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offers one item and returns at the edge where it is accepted. Valid is
  // only lowered when a gap follows, so back-to-back items keep it high.
  task automatic issue(input logic [2:0] k, input logic [4:0] hours,
                       input logic [5:0] minutes, input logic [5:0] seconds);
    event_item_t it;
    it.kind        = k;
    it.rtc_hours   = hours;
    it.rtc_minutes = minutes;
    it.rtc_seconds = seconds;
    event_item  <= it;
    event_valid <= 1'b1;
    @(posedge clk);
    while (!event_ready) @(posedge clk);
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      event_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Same as issue, with a random RTC time. Most times are legal; about one
  // in five uses the full field width so out-of-range digits appear.
  task automatic issue_kind(input logic [2:0] k);
    if ($urandom_range(0, 4) == 0) begin
      issue(k, 5'($urandom), 6'($urandom), 6'($urandom));
    end else begin
      issue(k, 5'($urandom_range(0, HOUR_MOD - 1)),
            6'($urandom_range(0, MINUTE_MOD - 1)),
            6'($urandom_range(0, MINUTE_MOD - 1)));
    end
  endtask

  // A full editing pass: long press to enter, usually the release that follows
  // it, then up/down/blink on each field and a short release to move on. The
  // short release after the seconds field commits. Now and then the pass
  // is aborted with a long press, and sometimes a step count is large
  // enough to wrap the field more than once.
  task automatic edit_session();
    int unsigned steps;
    int unsigned r;
    issue_kind(KIND_LONG);
    if ($urandom_range(0, 7) != 0) begin
      issue_kind(KIND_SHORT);
    end
    for (int f = 0; f < 3; f++) begin
      steps = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 65) : $urandom_range(0, 6);
      repeat (steps) begin
        r = $urandom_range(0, 19);
        if (r < 8) begin
          issue_kind(KIND_UP);
        end else if (r < 16) begin
          issue_kind(KIND_DOWN);
        end else if (r < 19) begin
          issue_kind(KIND_BLINK);
        end else begin
          issue_kind(KIND_TICK);
        end
      end
      if ($urandom_range(0, 11) == 0) begin
        issue_kind(KIND_LONG);
        if ($urandom_range(0, 1) == 0) begin
          issue_kind(KIND_SHORT);
        end
        return;
      end
      issue_kind(KIND_SHORT);
    end
  endtask

  // Normal-mode traffic: RTC ticks with the odd short release that leaves
  // the screen.
  task automatic tick_burst();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        issue_kind(KIND_SHORT);
      end else begin
        issue_kind(KIND_TICK);
      end
    end
  endtask

  // Any kind code, unused ones included, with fully random RTC fields.
  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      issue(3'($urandom_range(0, 7)), 5'($urandom), 6'($urandom), 6'($urandom));
    end
  endtask

  // Result side. Each pass sets ready once and then waits at least one edge,
  // so ready never gets two assignments in one time step. A hold-off request
  // from the stimulus turns into one long stall, counted here in cycles.
  initial begin : result_side
    int unsigned stall;
    result_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ready <= 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        stall = idle_len();
      end else begin
        result_ready <= 1'b1;
        stall = 1;
      end
      repeat (stall) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned session;
    int unsigned pick;
    int unsigned target;
    rst         = 1'b1;
    event_valid = 1'b0;
    event_item  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Normal mode first: ticks at the top and bottom of the
    // day, then the events that normal mode ignores.
    issue(KIND_TICK, 5'd23, 6'd59, 6'd59);
    issue(KIND_TICK, 5'd0, 6'd0, 6'd0);
    issue_kind(KIND_UP);
    issue_kind(KIND_DOWN);
    issue_kind(KIND_BLINK);
    issue_kind(KIND_SPARE_LO);
    issue_kind(KIND_SPARE_HI);
    // A short release in normal mode leaves the screen.
    issue_kind(KIND_SHORT);
    // All-ones RTC fields load digits beyond the legal range.
    issue(KIND_TICK, 5'd31, 6'd63, 6'd63);
    // Enter set mode; the release right after the long press is swallowed.
    issue_kind(KIND_LONG);
    issue_kind(KIND_SHORT);
    // Up on hour 31 wraps back into range; ticks are ignored while editing.
    issue_kind(KIND_UP);
    issue_kind(KIND_BLINK);
    issue_kind(KIND_TICK);
    issue_kind(KIND_SHORT);
    // Minutes 63 up, then seconds 63 down, both pulled back into range.
    issue_kind(KIND_UP);
    issue_kind(KIND_SHORT);
    issue_kind(KIND_DOWN);
    issue_kind(KIND_BLINK);
    // Short release after the seconds field commits and clears blink.
    issue_kind(KIND_SHORT);
    // Enter again, toggle blink, abort with a long press: no commit and the
    // blink phase is kept. The next release is swallowed, the one after it
    // leaves the screen.
    issue_kind(KIND_LONG);
    issue_kind(KIND_BLINK);
    issue_kind(KIND_LONG);
    issue_kind(KIND_SHORT);
    issue_kind(KIND_SHORT);

    // Random part: mostly well-formed editing passes, some normal-mode
    // traffic and some noise. Idling is switched off for whole stretches
    // now and then, and twice the result side stalls for a long time while
    // items keep coming back to back, so the core fills and holds its input.
    target  = items_sent + RANDOM_ITEMS;
    session = 0;
    while (items_sent < target) begin
      if (session % 10 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (session == 2 || session == 40) begin
        idle_on      = 1'b0;
        hold_off_req = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        edit_session();
      end else if (pick < 8) begin
        tick_burst();
      end else begin
        noise_burst();
      end
      session++;
    end
    event_valid <= 1'b0;

    // Drain: let the pending count take in the last item first, then wait for
    // every predicted result and then through DRAIN_CYCLES more, so a stray
    // extra result would still be caught.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("clock_time_set_controller_core regression: pass");
    end else begin
      $display("clock_time_set_controller_core regression: fail");
    end
    $finish;
  end

endmodule
